// ===== rtl/framed_packet_receiver_unit_defines.svh =====
// Assertion macros for the receiver RTL.
`ifndef FRAMED_PACKET_RECEIVER_UNIT_DEFINES_SVH
`define FRAMED_PACKET_RECEIVER_UNIT_DEFINES_SVH

// Check on the rising clock edge, skipped while reset is high.
`define FRX_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on the rising clock edge, reset included.
`define FRX_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/frx_pkg.sv =====
package frx_pkg;

   // Field widths
   localparam int RX_BYTE_W = 8;
   localparam int STATUS_W  = 4;
   localparam int LEN_W     = 12;
   localparam int TIMEOUT_W = 16;
   localparam int IDLE_W    = 17;
   localparam int SIZE_W    = 16;

   // Frame layout
   localparam int HEADER_BYTES = 4;

   // Protocol constants
   localparam logic [31:0] SYNC_WORD = 32'h817E_A345;
   localparam logic [31:0] CRC_POLY  = 32'h04C1_1DB7;
   localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd500;
   localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};
   localparam logic [1:0] LANE_LAST = 2'd3;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_NONE     = 4'd0;
   localparam logic [STATUS_W-1:0] STATUS_SYNC     = 4'd1;
   localparam logic [STATUS_W-1:0] STATUS_BODY     = 4'd2;
   localparam logic [STATUS_W-1:0] STATUS_OK       = 4'd3;
   localparam logic [STATUS_W-1:0] STATUS_CODE_ERR = 4'd4;
   localparam logic [STATUS_W-1:0] STATUS_SIZE_ERR = 4'd5;
   localparam logic [STATUS_W-1:0] STATUS_CRC_ERR  = 4'd6;
   localparam logic [STATUS_W-1:0] STATUS_OVERFULL = 4'd7;
   localparam logic [STATUS_W-1:0] STATUS_TIMEOUT  = 4'd8;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_HEAD = 2'd1,
      PH_BODY = 2'd2,
      PH_CRC  = 2'd3
   } frx_phase_type;

   typedef struct packed {
      logic                 req_type;
      logic [RX_BYTE_W-1:0] rx_byte;
   } frx_req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [RX_BYTE_W-1:0] cmd_code;
      logic [LEN_W-1:0]     body_length;
      logic [RX_BYTE_W-1:0] body_byte;
      logic [LEN_W-1:0]     body_index;
   } frx_rsp_item_type;

   // One 32-bit word through the MSB-first CRC-32, no reflection
   function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] word);
      logic [31:0] acc;
      acc = crc ^ word;
      for (int i = 0; i < 32; i++) begin
         acc = acc[31] ? ((acc << 1) ^ CRC_POLY) : (acc << 1);
      end
      return acc;
   endfunction

endpackage

// ===== rtl/frx_req_if.sv =====
interface frx_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] rx_byte;

   modport source (output valid, output req_type, output rx_byte, input ready);
   modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

// ===== rtl/frx_rsp_if.sv =====
interface frx_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [7:0]  cmd_code;
   logic [11:0] body_length;
   logic [7:0]  body_byte;
   logic [11:0] body_index;

   modport source (
      output valid, output status, output cmd_code, output body_length,
      output body_byte, output body_index, input ready
   );
   modport sink (
      input valid, input status, input cmd_code, input body_length,
      input body_byte, input body_index, output ready
   );
endinterface

// ===== rtl/framed_packet_receiver_unit.sv =====
// Framed packet receiver.
// req_chan carries one item per transfer: a received serial byte (req_type 0)
// or one timer tick (req_type 1). rsp_chan returns exactly one result per
// item: status, command code, body length and, for body bytes, the byte and
// its index. Body bytes are provisional until a packet-ok status follows.
// csr_wr_en/csr_wr_data load the timeout in ticks; write it only while idle.
// An item is taken into the input register, processed by the parser/CRC logic
// and its result is offered on rsp_chan by the result register. Throughput is
// one item per cycle while rsp_chan does not stall: the input register, the
// combinational parser/CRC logic and the result register advance together.
// When rsp_chan stalls, the result register holds, one more item waits in the
// input register and req_chan.ready then drops until the result is taken.
// Reset (synchronous, active high) empties both registers, sets the timeout
// to 500 ticks and starts hunting for the sync word with a cleared window.
`include "framed_packet_receiver_unit_defines.svh"

module framed_packet_receiver_unit import frx_pkg::*; #(
   parameter int BUFFER_BYTES = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   frx_req_if.sink              req_chan,
   frx_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [TIMEOUT_W-1:0] csr_wr_data
);

   logic             in_valid_ff, in_valid_in;
   frx_req_item_type in_item_ff, in_item_in;
   logic             rsp_valid_ff, rsp_valid_in;
   frx_rsp_item_type rsp_item_ff, rsp_item_in;

   logic             advance;
   logic             step;
   logic             req_take;
   frx_rsp_item_type core_result;
   frx_phase_type    core_phase;

   logic             sync_step;
   logic             body_step;
   logic             end_step;

   // Pipeline control
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign step           = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   frx_core #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (step),
      .item        (in_item_ff),
      .result      (core_result),
      .phase       (core_phase)
   );

   // Capture a new item, drop it once processed
   always_comb begin
      in_item_in = in_item_ff;
      priority if (req_take) begin
         in_valid_in         = 1'b1;
         in_item_in.req_type = req_chan.req_type;
         in_item_in.rx_byte  = req_chan.rx_byte;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Load a result, hold it until the transfer
   always_comb begin
      rsp_item_in = rsp_item_ff;
      priority if (step) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = core_result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_item_ff.status;
   assign rsp_chan.cmd_code    = rsp_item_ff.cmd_code;
   assign rsp_chan.body_length = rsp_item_ff.body_length;
   assign rsp_chan.body_byte   = rsp_item_ff.body_byte;
   assign rsp_chan.body_index  = rsp_item_ff.body_index;

   // Classify the processed item for the checks
   assign sync_step = step && (core_result.status == STATUS_SYNC);
   assign body_step = step && (core_result.status == STATUS_BODY);
   // every status from packet ok upward ends the frame
   assign end_step  = step && (core_result.status >= STATUS_OK);

   // Checks
   `FRX_ASSERT(a_no_step_on_stall, (rsp_valid_ff && !rsp_chan.ready) |-> !step, "step on stall")
   `FRX_ASSERT(a_sync_enters_header, sync_step |=> (core_phase == PH_HEAD), "no header after sync")
   `FRX_ASSERT(a_end_restarts, end_step |=> (core_phase == PH_HUNT), "no restart after frame end")
   `FRX_ASSERT(a_body_in_body_phase, body_step |-> (core_phase == PH_BODY), "body byte out of body")

endmodule

// ===== rtl/frx_core.sv =====
module frx_core import frx_pkg::*; #(
   parameter int BUFFER_BYTES = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [TIMEOUT_W-1:0] csr_wr_data,
   input  logic                 step,
   input  frx_req_item_type     item,
   output frx_rsp_item_type     result,
   output frx_phase_type        phase
);

   localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
   localparam logic [SIZE_W:0] MAX_SIZE = (SIZE_W + 1)'(BUFFER_BYTES - 8);
   localparam logic [CNT_W-1:0] HEAD_CNT = CNT_W'(HEADER_BYTES);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(BUFFER_BYTES);

   frx_phase_type        phase_ff, phase_in;
   logic [31:0]          sync_window_ff, sync_window_in;
   logic [CNT_W-1:0]     byte_count_ff, byte_count_in;
   logic [RX_BYTE_W-1:0] header_code_ff, header_code_in;
   logic [SIZE_W-1:0]    header_size_ff, header_size_in;
   logic [23:0]          word_gather_ff, word_gather_in;
   logic [31:0]          crc_accum_ff, crc_accum_in;
   logic [31:0]          received_crc_ff, received_crc_in;
   logic [IDLE_W-1:0]    idle_ticks_ff, idle_ticks_in;
   logic [TIMEOUT_W-1:0] timeout_ticks_ff, timeout_ticks_in;

   // Decode terms for the phase and data logic
   logic                 is_tick;
   logic [1:0]           lane;
   logic [1:0]           crc_lane;
   logic [31:0]          window_shift;
   logic [IDLE_W-1:0]    idle_inc;
   logic                 timeout_hit;
   logic                 sync_hit;
   logic [RX_BYTE_W-1:0] hdr_code;
   logic [SIZE_W-1:0]    hdr_size;
   logic                 hdr_done;
   logic                 code_bad;
   logic                 size_bad;
   logic [CNT_W-1:0]     count_inc;
   logic                 body_last;
   logic                 crc_last;
   logic [31:0]          crc_full;
   logic                 overfull;

   // Data path control
   logic                 gather;
   logic                 fresh;
   logic                 restart;
   logic [STATUS_W-1:0]  status;
   logic [RX_BYTE_W-1:0] body_byte;
   logic [LEN_W-1:0]     body_index;

   // Decode the item against the current state
   always_comb begin
      is_tick      = item.req_type;
      lane         = byte_count_ff[1:0];
      crc_lane     = byte_count_ff[1:0] - header_size_ff[1:0];
      window_shift = {sync_window_ff[23:0], item.rx_byte};
      idle_inc     = (idle_ticks_ff == IDLE_MAX) ? idle_ticks_ff : idle_ticks_ff + 1'b1;
      timeout_hit  = idle_inc > {1'b0, timeout_ticks_ff};
      sync_hit     = window_shift == SYNC_WORD;
      hdr_code     = word_gather_ff[7:0];
      hdr_size     = {item.rx_byte, word_gather_ff[23:16]};
      hdr_done     = lane == LANE_LAST;
      code_bad     = hdr_code != ~word_gather_ff[15:8];
      size_bad     = {1'b0, hdr_size} > MAX_SIZE;
      count_inc    = byte_count_ff + 1'b1;
      body_last    = count_inc >= (CNT_W'(header_size_ff) + HEAD_CNT);
      crc_last     = crc_lane == LANE_LAST;
      crc_full     = {item.rx_byte, received_crc_ff[23:0]};
      overfull     = count_inc >= FULL_CNT;
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         if (is_tick) begin
            if (timeout_hit) begin
               phase_in = PH_HUNT;
            end
         end else begin
            unique case (phase_ff)
               PH_HUNT: begin
                  if (sync_hit) begin
                     phase_in = PH_HEAD;
                  end
               end
               PH_HEAD: begin
                  if (hdr_done) begin
                     priority if (code_bad || size_bad) begin
                        phase_in = PH_HUNT;
                     end else if (hdr_size == '0) begin
                        phase_in = PH_CRC;
                     end else begin
                        phase_in = PH_BODY;
                     end
                  end
               end
               PH_BODY: begin
                  if (body_last) begin
                     phase_in = PH_CRC;
                  end
               end
               PH_CRC: begin
                  if (crc_last) begin
                     phase_in = PH_HUNT;
                  end
               end
               default: phase_in = PH_HUNT;
            endcase
         end
      end
   end

   // Data registers and result
   always_comb begin
      sync_window_in   = sync_window_ff;
      byte_count_in    = byte_count_ff;
      header_code_in   = header_code_ff;
      header_size_in   = header_size_ff;
      word_gather_in   = word_gather_ff;
      crc_accum_in     = crc_accum_ff;
      received_crc_in  = received_crc_ff;
      idle_ticks_in    = idle_ticks_ff;
      timeout_ticks_in = csr_wr_en ? csr_wr_data : timeout_ticks_ff;
      gather           = 1'b0;
      fresh            = 1'b0;
      restart          = 1'b0;
      status           = STATUS_NONE;
      body_byte        = '0;
      body_index       = '0;

      if (step) begin
         if (is_tick) begin
            idle_ticks_in = idle_inc;
            if (timeout_hit) begin
               status  = STATUS_TIMEOUT;
               restart = 1'b1;
            end
         end else begin
            unique case (phase_ff)
               PH_HUNT: begin
                  sync_window_in = window_shift;
                  if (sync_hit) begin
                     status = STATUS_SYNC;
                     fresh  = 1'b1;
                  end
               end
               PH_HEAD: begin
                  gather        = 1'b1;
                  byte_count_in = count_inc;
                  if (hdr_done) begin
                     header_code_in = hdr_code;
                     header_size_in = hdr_size;
                     priority if (code_bad) begin
                        status  = STATUS_CODE_ERR;
                        restart = 1'b1;
                     end else if (size_bad) begin
                        status  = STATUS_SIZE_ERR;
                        restart = 1'b1;
                     end
                  end
               end
               PH_BODY: begin
                  status        = STATUS_BODY;
                  body_byte     = item.rx_byte;
                  body_index    = LEN_W'(byte_count_ff - HEAD_CNT);
                  gather        = 1'b1;
                  byte_count_in = count_inc;
               end
               PH_CRC: begin
                  received_crc_in = received_crc_ff | (32'(item.rx_byte) << {crc_lane, 3'b000});
                  byte_count_in   = count_inc;
                  if (crc_last) begin
                     priority if (overfull) begin
                        status = STATUS_OVERFULL;
                     end else if (crc_full != crc_accum_ff) begin
                        status = STATUS_CRC_ERR;
                     end else begin
                        status = STATUS_OK;
                     end
                     restart = 1'b1;
                  end
               end
               default: restart = 1'b1;
            endcase
         end
      end

      // Feed header and body bytes into the word CRC
      if (gather) begin
         if (lane == LANE_LAST) begin
            crc_accum_in   = crc_word(crc_accum_ff, {item.rx_byte, word_gather_ff});
            word_gather_in = '0;
         end else begin
            word_gather_in = word_gather_ff | (24'(item.rx_byte) << {lane, 3'b000});
         end
      end

      // Start a new frame or drop back to hunting
      if (fresh || restart) begin
         byte_count_in   = '0;
         word_gather_in  = '0;
         received_crc_in = '0;
         crc_accum_in    = CRC_INIT;
      end
      if (restart) begin
         idle_ticks_in = '0;
      end
   end

   assign result.status      = status;
   assign result.cmd_code    = header_code_in;
   assign result.body_length = header_size_in[LEN_W-1:0];
   assign result.body_byte   = body_byte;
   assign result.body_index  = body_index;
   assign phase              = phase_ff;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HUNT;
         sync_window_ff   <= '0;
         byte_count_ff    <= '0;
         header_code_ff   <= '0;
         header_size_ff   <= '0;
         word_gather_ff   <= '0;
         crc_accum_ff     <= CRC_INIT;
         received_crc_ff  <= '0;
         idle_ticks_ff    <= '0;
         timeout_ticks_ff <= TIMEOUT_RESET;
      end else begin
         phase_ff         <= phase_in;
         sync_window_ff   <= sync_window_in;
         byte_count_ff    <= byte_count_in;
         header_code_ff   <= header_code_in;
         header_size_ff   <= header_size_in;
         word_gather_ff   <= word_gather_in;
         crc_accum_ff     <= crc_accum_in;
         received_crc_ff  <= received_crc_in;
         idle_ticks_ff    <= idle_ticks_in;
         timeout_ticks_ff <= timeout_ticks_in;
      end
   end

endmodule
